[rtl/rsp_pkg.sv]
package rsp_pkg;

  localparam int MAX_DEGREE = 30;
  localparam int RESET_DEGREE = 10;
  localparam int ECC_DEGREE_W = 5;
  localparam logic [7:0] GF_POLY_LOW = 8'h1D;

  typedef struct packed {
    logic       init;
    logic       clear;
    logic       iter;
    logic       step;
    logic       close;
    logic       shift;
    logic [7:0] root;
    logic [7:0] factor;
  } cell_ctrl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int bit_idx = 7; bit_idx >= 0; bit_idx--) begin
      acc = xtime(acc);
      if (b[bit_idx]) begin
        acc = acc ^ a;
      end
    end
    gf_mul = acc;
  endfunction

endpackage

[rtl/rsp_cell.sv]
module rsp_cell #(
  parameter int DW  = 5,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  rsp_pkg::cell_ctrl_t ctrl,
  input  logic [DW-1:0]       init_deg,
  input  logic [7:0]          g_up,
  input  logic [7:0]          r_up,
  input  logic [7:0]          p_up,
  output logic [7:0]          g,
  output logic [7:0]          r,
  output logic [7:0]          p
);

  logic [7:0] mul;
  logic [7:0] r_next;
  logic       top;

  assign mul    = rsp_pkg::gf_mul(g, ctrl.iter ? ctrl.root : ctrl.factor);
  assign r_next = r_up ^ mul;
  assign top    = (init_deg == DW'(IDX + 1));

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      g <= top ? 8'h01 : 8'h00;
    end else if (ctrl.iter) begin
      g <= mul ^ g_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      r <= 8'h00;
    end else if (ctrl.step) begin
      r <= ctrl.close ? 8'h00 : r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && ctrl.close) begin
      p <= r_next;
    end else if (ctrl.shift) begin
      p <= p_up;
    end
  end

endmodule

[rtl/reed_solomon_parity_encoder.sv]
// Parity for a block is valid in the cycle after its last data beat is taken.
// Throughput: one data beat per cycle when not stalled; d parity beats per block, one
// per cycle while parity_ready is high, overlapping the next block's data. A last beat
// waits while the prior block's parity is pending, unless only its final parity beat
// remains and is taken that cycle. Reset and every degree write rebuild the generator,
// one root per cycle through the cell row; data_ready is low during write and rebuild.
module reed_solomon_parity_encoder #(
  parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rsp_pkg::ECC_DEGREE_W-1:0] cfg_wr_data,
  input  logic                            data_valid,
  output logic                            data_ready,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  output logic                            parity_valid,
  input  logic                            parity_ready,
  output logic [7:0]                      parity_byte,
  output logic                            last_parity
);

  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int CW = (DW > rsp_pkg::ECC_DEGREE_W) ? DW : rsp_pkg::ECC_DEGREE_W;

  logic [DW-1:0] deg;
  logic [DW-1:0] bld_cnt;
  logic [DW-1:0] pcnt;
  logic [7:0]    root;
  logic [CW-1:0] deg_raw;
  logic [DW-1:0] deg_new;
  logic          init;
  logic          busy;
  logic          load_ok;
  logic          accept;
  logic          shift;

  logic [7:0] g_arr [MAX_DEGREE+1];
  logic [7:0] r_arr [MAX_DEGREE+1];
  logic [7:0] p_arr [MAX_DEGREE+1];

  rsp_pkg::cell_ctrl_t ctrl;

  assign init    = rst || cfg_wr_en;
  assign deg_raw = rst ? CW'(rsp_pkg::RESET_DEGREE) : CW'(cfg_wr_data);

  always_comb begin
    priority if (deg_raw == '0) begin
      deg_new = DW'(1);
    end else if (deg_raw > CW'(MAX_DEGREE)) begin
      deg_new = DW'(MAX_DEGREE);
    end else begin
      deg_new = deg_raw[DW-1:0];
    end
  end

  assign busy         = (bld_cnt != '0);
  assign parity_valid = (pcnt != '0);
  assign last_parity  = (pcnt == DW'(1));
  assign parity_byte  = p_arr[0];
  assign shift        = parity_valid && parity_ready;
  assign load_ok      = (pcnt == '0) || ((pcnt == DW'(1)) && parity_ready);
  assign data_ready   = !init && !busy && (!last_byte || load_ok);
  assign accept       = data_valid && data_ready;

  always_comb begin
    ctrl.init   = init;
    ctrl.clear  = init;
    ctrl.iter   = busy && !init;
    ctrl.step   = accept && !init;
    ctrl.close  = last_byte;
    ctrl.shift  = shift;
    ctrl.root   = root;
    ctrl.factor = data_byte ^ r_arr[0];
  end

  always_ff @(posedge clk) begin
    if (init) begin
      deg     <= deg_new;
      bld_cnt <= deg_new;
      root    <= 8'h01;
    end else if (busy) begin
      bld_cnt <= bld_cnt - DW'(1);
      root    <= rsp_pkg::xtime(root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= '0;
    end else if (accept && last_byte) begin
      pcnt <= deg;
    end else if (shift) begin
      pcnt <= pcnt - DW'(1);
    end
  end

  assign g_arr[MAX_DEGREE] = 8'h00;
  assign r_arr[MAX_DEGREE] = 8'h00;
  assign p_arr[MAX_DEGREE] = 8'h00;

  for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_cell
    rsp_cell #(
      .DW  (DW),
      .IDX (j)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .init_deg (deg_new),
      .g_up     (g_arr[j+1]),
      .r_up     (r_arr[j+1]),
      .p_up     (p_arr[j+1]),
      .g        (g_arr[j]),
      .r        (r_arr[j]),
      .p        (p_arr[j])
    );
  end

endmodule
